### hw/rtl/pncm_pkg.sv
// Shared constants, types and control structs of the palette color mapper.
`default_nettype none
package pncm_pkg;

  // Palette geometry
  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int SIZE_W        = 9;
  localparam logic [SIZE_W-1:0] DEPTH_SZ = SIZE_W'(PALETTE_DEPTH);
  localparam logic [SIZE_W-1:0] MIN_SZ   = SIZE_W'(2);

  // Channel widths
  localparam int CH_W       = 8;
  localparam int IDX_W      = 8;
  localparam int ENTRY_W    = 3 * CH_W;
  localparam int DIST_W     = 18;
  localparam int IN_TDATA_W = 48;

  // Input word layout (tdata bit offsets)
  localparam int OFS_ENTRY = 0;
  localparam int OFS_ALPHA = 8;
  localparam int OFS_RED   = 16;
  localparam int OFS_GREEN = 24;
  localparam int OFS_BLUE  = 32;
  localparam int OFS_PRIOR = 40;

  // Input word kinds
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  // Configuration register indexes
  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] REG_PALETTE_SIZE    = 1'b0;
  localparam logic [CFG_AW-1:0] REG_ALPHA_THRESHOLD = 1'b1;
  localparam int CFG_DW = 9;

  localparam logic [SIZE_W-1:0] RST_PALETTE_SIZE    = 9'd256;
  localparam logic [CH_W-1:0]   RST_ALPHA_THRESHOLD = 8'd127;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_PUSH  = 4'b1000
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_we;     // write palette entry from the input word
    logic pix_take;    // latch pixel, resolve fast path or arm the scan
    logic scan_issue;  // read next palette entry and advance
    logic out_load;    // move result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fast_path;   // current input pixel needs no search
    logic issue_last;  // scan address is the last entry to check
    logic hit;         // exact match found, search may stop
    logic pipe_empty;  // no read in flight
    logic out_free;    // output register can take a word
  } sts_t;

endpackage
`default_nettype wire

### hw/rtl/pncm_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module pncm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/pncm_ctrl.sv
// Controller state machine sequencing loads, fast pixels and palette scans.
`default_nettype none
module pncm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  wire logic          in_mode,
  output logic               in_tready,
  input  wire pncm_pkg::sts_t sts,
  output pncm_pkg::cmd_t     cmd
);

  pncm_pkg::state_t state_r, state_nxt;
  logic             accept;

  assign in_tready = (state_r == pncm_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    case (state_r)
      pncm_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_mode == pncm_pkg::MODE_LOAD) begin
            cmd.load_we = 1'b1;
          end else begin
            cmd.pix_take = 1'b1;
            state_nxt    = sts.fast_path ? pncm_pkg::ST_PUSH : pncm_pkg::ST_SCAN;
          end
        end
      end
      pncm_pkg::ST_SCAN: begin
        // stop issuing once an exact match is known
        cmd.scan_issue = !sts.hit;
        if (sts.hit || sts.issue_last) begin
          state_nxt = pncm_pkg::ST_DRAIN;
        end
      end
      pncm_pkg::ST_DRAIN: begin
        if (sts.pipe_empty) begin
          state_nxt = pncm_pkg::ST_PUSH;
        end
      end
      pncm_pkg::ST_PUSH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = pncm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pncm_pkg::ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pncm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/pncm_dp.sv
// Datapath: config registers, palette RAM, distance pipeline, output register.
`default_nettype none
module pncm_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [pncm_pkg::CFG_AW-1:0]         cfg_addr,
  input  wire logic [pncm_pkg::CFG_DW-1:0]         cfg_wdata,
  input  wire logic [pncm_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire logic                                out_tready,
  output logic                                     out_tvalid,
  output logic      [pncm_pkg::IDX_W-1:0]          out_idx,
  output logic                                     out_transp,
  input  wire pncm_pkg::cmd_t                      cmd,
  output pncm_pkg::sts_t                           sts
);

  localparam int AW = pncm_pkg::PAL_AW;
  localparam int CW = pncm_pkg::CH_W;
  localparam int SW = pncm_pkg::SIZE_W;
  localparam int DW = pncm_pkg::DIST_W;

  // Input word fields
  logic [CW-1:0] f_entry, f_alpha, f_red, f_green, f_blue, f_prior;
  assign f_entry = in_tdata[pncm_pkg::OFS_ENTRY +: CW];
  assign f_alpha = in_tdata[pncm_pkg::OFS_ALPHA +: CW];
  assign f_red   = in_tdata[pncm_pkg::OFS_RED   +: CW];
  assign f_green = in_tdata[pncm_pkg::OFS_GREEN +: CW];
  assign f_blue  = in_tdata[pncm_pkg::OFS_BLUE  +: CW];
  assign f_prior = in_tdata[pncm_pkg::OFS_PRIOR +: CW];

  // Configuration registers
  logic [SW-1:0] psize_r;
  logic [CW-1:0] athr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psize_r <= pncm_pkg::RST_PALETTE_SIZE;
      athr_r  <= pncm_pkg::RST_ALPHA_THRESHOLD;
    end else if (cfg_we) begin
      if (cfg_addr == pncm_pkg::REG_PALETTE_SIZE) begin
        psize_r <= cfg_wdata[SW-1:0];
      end
      if (cfg_addr == pncm_pkg::REG_ALPHA_THRESHOLD) begin
        athr_r <= cfg_wdata[CW-1:0];
      end
    end
  end

  // Clamp palette size into its legal range
  logic [SW-1:0] eff_size, transp_idx, last_ent;
  always_comb begin
    eff_size = psize_r;
    if (psize_r < pncm_pkg::MIN_SZ) begin
      eff_size = pncm_pkg::MIN_SZ;
    end else if (psize_r > pncm_pkg::DEPTH_SZ) begin
      eff_size = pncm_pkg::DEPTH_SZ;
    end
  end
  assign transp_idx = eff_size - SW'(1);
  assign last_ent   = eff_size - SW'(2);

  // Classify the incoming pixel
  logic is_transp, fast;
  assign is_transp = (f_alpha < athr_r);
  assign fast      = is_transp || (f_prior != '0);

  // Pixel and fast-path result holding
  logic [CW-1:0]                 pix_r_r, pix_g_r, pix_b_r;
  logic [pncm_pkg::IDX_W-1:0]    res_idx_r;
  logic                          res_transp_r, res_fast_r;

  always_ff @(posedge clk) begin
    if (cmd.pix_take) begin
      pix_r_r      <= f_red;
      pix_g_r      <= f_green;
      pix_b_r      <= f_blue;
      res_idx_r    <= is_transp ? transp_idx[pncm_pkg::IDX_W-1:0] : f_prior;
      res_transp_r <= is_transp;
      res_fast_r   <= fast;
    end
  end

  // Palette memory
  logic                        ram_we;
  logic [AW-1:0]               scan_addr_r;
  logic [pncm_pkg::ENTRY_W-1:0] ram_rdata;

  assign ram_we = cmd.load_we && ({1'b0, f_entry} < pncm_pkg::DEPTH_SZ);

  pncm_ram #(
    .WIDTH (pncm_pkg::ENTRY_W),
    .DEPTH (pncm_pkg::PALETTE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (f_entry[AW-1:0]),
    .wdata ({f_red, f_green, f_blue}),
    .raddr (scan_addr_r),
    .rdata (ram_rdata)
  );

  // Scan address counter
  always_ff @(posedge clk) begin
    if (cmd.pix_take) begin
      scan_addr_r <= '0;
    end else if (cmd.scan_issue) begin
      scan_addr_r <= scan_addr_r + AW'(1);
    end
  end

  // Pipeline valid bits and indexes
  logic          v1_r, v2_r;
  logic [AW-1:0] idx1_r, idx2_r;
  logic [DW-1:0] d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.scan_issue;
      v2_r <= v1_r;
    end
  end

  // Stage 1: squared RGB distance of the entry just read
  logic [CW-1:0]   er, eg, eb, dr, dg, db;
  logic [2*CW-1:0] sq_r, sq_g, sq_b;
  assign er = ram_rdata[2*CW +: CW];
  assign eg = ram_rdata[CW   +: CW];
  assign eb = ram_rdata[0    +: CW];
  assign dr = (er > pix_r_r) ? er - pix_r_r : pix_r_r - er;
  assign dg = (eg > pix_g_r) ? eg - pix_g_r : pix_g_r - eg;
  assign db = (eb > pix_b_r) ? eb - pix_b_r : pix_b_r - eb;
  assign sq_r = dr * dr;
  assign sq_g = dg * dg;
  assign sq_b = db * db;

  always_ff @(posedge clk) begin
    idx1_r <= scan_addr_r;
    idx2_r <= idx1_r;
    d2_r   <= DW'(sq_r) + DW'(sq_g) + DW'(sq_b);
  end

  // Stage 2: keep the best entry, lowest index on ties
  logic [DW-1:0] best_dist_r;
  logic [AW-1:0] best_idx_r;
  logic          found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.pix_take) begin
      found_r <= 1'b0;
    end else if (v2_r && !found_r && (d2_r < best_dist_r) && (d2_r == '0)) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_take) begin
      best_dist_r <= '1;
      best_idx_r  <= '0;
    end else if (v2_r && !found_r && (d2_r < best_dist_r)) begin
      best_dist_r <= d2_r;
      best_idx_r  <= idx2_r;
    end
  end

  // Output register
  logic                       out_valid_r;
  logic [pncm_pkg::IDX_W-1:0] out_idx_r;
  logic                       out_transp_r;
  logic                       out_free;

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_idx_r    <= res_fast_r ? res_idx_r : pncm_pkg::IDX_W'(best_idx_r);
      out_transp_r <= res_fast_r && res_transp_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_idx    = out_idx_r;
  assign out_transp = out_transp_r;

  // Status to the controller
  assign sts.fast_path  = fast;
  assign sts.issue_last = (scan_addr_r == last_ent[AW-1:0]);
  assign sts.hit        = found_r;
  assign sts.pipe_empty = !v1_r && !v2_r;
  assign sts.out_free   = out_free;

endmodule
`default_nettype wire

### hw/rtl/palette_nearest_color_mapper_unit.sv
// Top level: maps ARGB pixels to nearest palette indices; a waiting result stalls the input.
// Load word: palette write at accept, no result; loads go at one per cycle.
// Transparent or pre-assigned pixel: no search, result to output register, then next word.
// Searched pixel: N-1 reads at one per cycle (N = clamped palette size); an exact
//   match stops them; result registered once drained and output free, then next word.
// Reset (rst_n low, synchronous): controller idle, output empty, size 256, threshold 127.
`default_nettype none
module palette_nearest_color_mapper_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration
  input  wire logic                                cfg_we,
  input  wire logic [pncm_pkg::CFG_AW-1:0]         cfg_addr,
  input  wire logic [pncm_pkg::CFG_DW-1:0]         cfg_wdata,
  // input words
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // entry_index, alpha, red, green, blue, prior_index (lowest bits first)
  input  wire logic [pncm_pkg::IN_TDATA_W-1:0]     in_tdata,
  // mode
  input  wire logic                                in_tuser,
  // result words
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // palette_index
  output logic      [pncm_pkg::IDX_W-1:0]          out_tdata,
  // is_transparent
  output logic                                     out_tuser
);

  pncm_pkg::cmd_t cmd;
  pncm_pkg::sts_t sts;

  pncm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pncm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_idx    (out_tdata),
    .out_transp (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

  // Commands are mutually exclusive
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_we, cmd.pix_take, cmd.scan_issue, cmd.out_load}))
    else $error("more than one datapath command at once");

  // No palette read after an exact match
  a_no_issue_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_issue |-> !sts.hit)
    else $error("palette read issued after exact match");

  // Result only loaded when the output register can take it
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten");

  // A result is loaded only once no read is in flight
  a_out_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.pipe_empty)
    else $error("result loaded with scan still in flight");

endmodule
`default_nettype wire

### tb/tb_palette_nearest_color_mapper_unit.sv
// Self-checking testbench for the palette nearest color mapper: predicts each mapped pixel.
`timescale 1ns / 1ps
module tb_palette_nearest_color_mapper_unit;
  import pncm_pkg::*;

  // One expected result word
  typedef struct packed {
    logic [IDX_W-1:0] pal_index;
    logic             transp;
  } mapping_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = REG_PALETTE_SIZE;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = MODE_LOAD;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [IDX_W-1:0] out_tdata;
  logic out_tuser;

  // Shadow of the block: palette contents, which slots hold data, registers
  logic [ENTRY_W-1:0] palette_rgb [PALETTE_DEPTH];
  bit                 loaded [PALETTE_DEPTH];
  logic [SIZE_W-1:0]  size_reg = RST_PALETTE_SIZE;
  logic [CH_W-1:0]    thresh_reg = RST_ALPHA_THRESHOLD;

  mapping_t pending_maps [$];
  int  error_count = 0;
  bit  steady = 1'b0;
  int  hold_cycles_req = 0;

  palette_nearest_color_mapper_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Palette size after saturation into 2 .. depth
  function automatic int active_size();
    int n;
    n = size_reg;
    if (n < 2) n = 2;
    if (n > PALETTE_DEPTH) n = PALETTE_DEPTH;
    return n;
  endfunction

  // A search may only touch slots that were loaded since reset
  function automatic bit search_ok();
    for (int i = 0; i < active_size() - 1; i++)
      if (!loaded[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic mapping_t predict_mapping(input logic [7:0] alpha, red, green, blue,
                                               prior);
    mapping_t m;
    int n;
    int best;
    int dr, dg, db, d;
    n = active_size();
    m.transp = 1'b0;
    m.pal_index = '0;
    if (alpha < thresh_reg) begin
      m.pal_index = IDX_W'(n - 1);
      m.transp = 1'b1;
    end else if (prior != 0) begin
      m.pal_index = prior;
    end else begin
      best = 32'h7fff_ffff;
      for (int i = 0; i < n - 1; i++) begin
        dr = int'(palette_rgb[i][23:16]) - int'(red);
        dg = int'(palette_rgb[i][15:8]) - int'(green);
        db = int'(palette_rgb[i][7:0]) - int'(blue);
        d = dr * dr + dg * dg + db * db;
        // strict compare keeps the lowest index on ties; exact match stops the walk
        if (d < best) begin
          best = d;
          m.pal_index = IDX_W'(i);
          if (d == 0) break;
        end
      end
    end
    return m;
  endfunction

  // Offer one word, hold it until taken, then update the shadow state
  task automatic offer_word(input logic mode, input logic [7:0] slot, alpha, red, green,
                            blue, prior);
    while (!steady && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {prior, blue, green, red, alpha, slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (mode == MODE_LOAD) begin
      palette_rgb[slot] = {red, green, blue};
      loaded[slot] = 1'b1;
    end else begin
      pending_maps.insert(pending_maps.size(),
                          predict_mapping(alpha, red, green, blue, prior));
    end
  endtask

  task automatic load_entry(input logic [7:0] slot, red, green, blue);
    offer_word(MODE_LOAD, slot, 8'($urandom), red, green, blue, 8'($urandom));
  endtask

  task automatic map_pixel(input logic [7:0] alpha, red, green, blue, prior);
    offer_word(MODE_PIXEL, 8'($urandom), alpha, red, green, blue, prior);
  endtask

  // Load a random slot, mostly inside the active palette; coarse colors force duplicates
  task automatic random_load(input int n);
    logic [7:0] slot;
    logic [23:0] c;
    slot = ($urandom_range(3) != 0) ? 8'($urandom_range(n - 1, 0)) : 8'($urandom_range(255));
    if ($urandom_range(3) == 0)
      c = {8'($urandom_range(2) * 127), 8'($urandom_range(2) * 127),
           8'($urandom_range(2) * 127)};
    else
      c = 24'($urandom);
    load_entry(slot, c[23:16], c[15:8], c[7:0]);
  endtask

  // Mix of transparent, pre-assigned, exact-hit and searched pixels
  task automatic random_pixel();
    int kind;
    int k;
    logic [7:0] a, p;
    logic [23:0] c;
    kind = $urandom_range(99);
    c = 24'($urandom);
    a = 8'($urandom_range(255, thresh_reg));
    p = '0;
    if (kind < 15 && thresh_reg != 0) begin
      a = 8'($urandom_range(thresh_reg - 1, 0));
      p = 8'($urandom);
    end else if (kind < 35) begin
      p = 8'($urandom_range(255, 1));
    end else if (kind < 55) begin
      k = $urandom_range(active_size() - 2, 0);
      if (loaded[k]) c = palette_rgb[k];
    end
    // never let a search read a slot that was not loaded
    if (p == 0 && a >= thresh_reg && !search_ok()) p = 8'($urandom_range(255, 1));
    map_pixel(a, c[23:16], c[15:8], c[7:0], p);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == REG_PALETTE_SIZE) size_reg = value;
    else thresh_reg = value[CH_W-1:0];
    @(posedge clk);
  endtask

  // Drop valid, wait for every expected word, then let a trailing load land
  task automatic settle_block();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    write_reg(REG_PALETTE_SIZE, 9'd4);
    load_entry(8'd0, 8'd0, 8'd0, 8'd0);
    load_entry(8'd1, 8'd2, 8'd0, 8'd0);
    load_entry(8'd2, 8'd255, 8'd255, 8'd255);
    load_entry(8'd255, 8'h5a, 8'ha5, 8'h3c);
    // tie between entries 0 and 1: lowest index wins
    map_pixel(8'd255, 8'd1, 8'd0, 8'd0, 8'd0);
    // exact hit on the last searched entry, alpha right at threshold
    map_pixel(8'd127, 8'd255, 8'd255, 8'd255, 8'd0);
    map_pixel(8'd200, 8'd200, 8'd10, 8'd10, 8'd0);
    // transparent, also overriding a prior index
    map_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    map_pixel(8'd126, 8'd9, 8'd9, 8'd9, 8'd200);
    // prior index beyond the palette passes through
    map_pixel(8'd255, 8'd7, 8'd7, 8'd7, 8'd255);
    map_pixel(8'd128, 8'd7, 8'd7, 8'd7, 8'd1);
    settle_block();
    // sizes 0 and 1 act as 2
    write_reg(REG_PALETTE_SIZE, 9'd0);
    map_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd0);
    map_pixel(8'd3, 8'd255, 8'd255, 8'd255, 8'd0);
    settle_block();
    write_reg(REG_PALETTE_SIZE, 9'd1);
    map_pixel(8'd100, 8'd1, 8'd2, 8'd3, 8'd0);
    settle_block();
    // oversize palette saturates to depth; highest threshold
    write_reg(REG_PALETTE_SIZE, 9'd511);
    write_reg(REG_ALPHA_THRESHOLD, 9'd255);
    map_pixel(8'd254, 8'd0, 8'd0, 8'd0, 8'd0);
    map_pixel(8'd255, 8'd0, 8'd0, 8'd0, 8'd7);
    settle_block();
    // threshold zero: nothing is transparent
    write_reg(REG_ALPHA_THRESHOLD, 9'd0);
    map_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd9);
    settle_block();
    write_reg(REG_PALETTE_SIZE, 9'd2);
    map_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    settle_block();
  endtask

  // Fill the whole palette in order, then map random pixels; searches cover every entry but the last
  task automatic test_full_palette_search();
    logic [23:0] c;
    write_reg(REG_PALETTE_SIZE, 9'd256);
    write_reg(REG_ALPHA_THRESHOLD, 9'd60);
    for (int i = 0; i < PALETTE_DEPTH; i++) begin
      if ($urandom_range(3) == 0)
        c = {8'($urandom_range(2) * 127), 8'($urandom_range(2) * 127),
             8'($urandom_range(2) * 127)};
      else
        c = 24'($urandom);
      load_entry(8'(i), c[23:16], c[15:8], c[7:0]);
    end
    repeat (150) random_pixel();
    settle_block();
  endtask

  // Phases of a new size and threshold, a few reloads, then a burst of pixels
  task automatic test_palette_phases();
    int sent;
    int pick;
    int count;
    int n;
    sent = 0;
    while (sent < 1150) begin
      pick = $urandom_range(9);
      case (pick)
        0, 1, 2, 3, 4, 5: write_reg(REG_PALETTE_SIZE, 9'($urandom_range(24, 2)));
        6: write_reg(REG_PALETTE_SIZE, 9'($urandom_range(1, 0)));
        7: write_reg(REG_PALETTE_SIZE, 9'd256);
        8: write_reg(REG_PALETTE_SIZE, 9'($urandom_range(511, 257)));
        default: write_reg(REG_PALETTE_SIZE, 9'($urandom_range(64, 25)));
      endcase
      pick = $urandom_range(9);
      if (pick == 0) write_reg(REG_ALPHA_THRESHOLD, 9'd0);
      else if (pick == 1) write_reg(REG_ALPHA_THRESHOLD, 9'd255);
      else write_reg(REG_ALPHA_THRESHOLD, 9'($urandom_range(255)));
      n = active_size();
      count = $urandom_range(12, 2);
      repeat (count) random_load(n);
      sent += count;
      count = (n > 64) ? $urandom_range(16, 6) : $urandom_range(40, 15);
      // pixels with the odd reload between them
      repeat (count) begin
        if ($urandom_range(9) == 0) random_load(n);
        else random_pixel();
      end
      sent += count;
      settle_block();
    end
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_steady_stream();
    write_reg(REG_PALETTE_SIZE, 9'd12);
    write_reg(REG_ALPHA_THRESHOLD, 9'd127);
    steady = 1'b1;
    repeat (150) begin
      if ($urandom_range(3) == 0) random_load(12);
      else random_pixel();
    end
    settle_block();
    steady = 1'b0;
  endtask

  // Hold the output off long enough that the block stops taking words
  task automatic test_output_backpressure();
    write_reg(REG_PALETTE_SIZE, 9'd8);
    hold_cycles_req = 300;
    repeat (40) random_pixel();
    settle_block();
  endtask

  // Receiver: random stalls, or one long hold when requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles_req != 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles_req) @(posedge clk);
        hold_cycles_req = 0;
      end else if (!steady && $urandom_range(99) < 23) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : check_result
    mapping_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_maps.size() == 0) begin
        $error("unexpected result word: palette_index=%0d is_transparent=%0d",
               out_tdata, out_tuser);
        error_count++;
      end else begin
        want = pending_maps.pop_front();
        if (out_tdata !== want.pal_index) begin
          $error("palette_index: expected %0d, got %0d", want.pal_index, out_tdata);
          error_count++;
        end
        if (out_tuser !== want.transp) begin
          $error("is_transparent: expected %0d, got %0d", want.transp, out_tuser);
          error_count++;
        end
      end
    end
  end

  initial begin
    #60_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_full_palette_search();
    test_palette_phases();
    test_steady_stream();
    test_output_backpressure();
    settle_block();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/pncm_pkg.sv
hw/rtl/pncm_ram.sv
hw/rtl/pncm_ctrl.sv
hw/rtl/pncm_dp.sv
hw/rtl/palette_nearest_color_mapper_unit.sv
tb/tb_palette_nearest_color_mapper_unit.sv
